/* src/ldrs_pkg.sv */
// Shared types and constants for the decimal LSD radix sorter.
// No dependencies; imported by lsd_decimal_radix_sort.
`default_nettype none

package ldrs_pkg;

  localparam int DigitBase = 10;
  localparam logic [3:0] DigitLast = 4'(DigitBase - 1);

  // floor(q / 10) == (q * RecipTen) >> RecipShift for every q below 2^32
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;

  localparam int FieldBits = 31;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } ldrs_state_e;

endpackage

`default_nettype wire

/* src/lsd_decimal_radix_sort.sv */
// Decimal LSD radix sorter: collects a set of words, sorts it stably by
// decimal digit, emits it in ascending order. Depends on ldrs_pkg.
`default_nettype none

//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o   | value_i, last_item_i
//  out     | out_valid_o / out_stall_i | sorted_value_o, last_out_o, overflow_o
//
// Loading accepts one word per cycle. After the word marked last, the sort runs
// P passes, P being the decimal digit count of the largest value (at least 1);
// a pass over n words is a count sweep and a scatter sweep through the shared
// divide-by-ten unit and the two stores, plus ten prefix steps. Output then
// reads each word into the output register and holds it until taken; the
// input is stalled from the last word until the final result is taken.
// Reset is asynchronous and clears control state only; the stores are not
// cleared. A stalled result word holds until taken.

module lsd_decimal_radix_sort #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [ldrs_pkg::FieldBits-1:0] value_i,
  input  wire logic                          last_item_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [ldrs_pkg::FieldBits-1:0] sorted_value_o,
  output      logic                          last_out_o,
  output      logic                          overflow_o
);

  import ldrs_pkg::*;

  // stored value width: the port carries at most FieldBits
  localparam int SW = (VALUE_BITS < FieldBits) ? VALUE_BITS : FieldBits;
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = SW + 32;
  localparam int EW = 2 * SW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

  ldrs_state_e st_q, st_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          s1_v_q, s2_v_q;
  logic          src_q, src_d;
  logic          more_q, more_d;
  logic [3:0]    pidx_q, pidx_d;
  logic [CW-1:0] acc_q, acc_d;
  logic [CW-1:0] cs_q [DigitBase];

  logic [PW-1:0] prod_q;
  logic [SW-1:0] val_s2_q, q_s2_q;
  logic [FieldBits-1:0] sorted_q;
  logic          last_q, ovf_q;

  // stores: each entry holds {value, value / 10^pass}
  logic [EW-1:0] mem_a [MAX_ITEMS];
  logic [EW-1:0] mem_b [MAX_ITEMS];
  logic [EW-1:0] a_rd_q, b_rd_q;

  logic          in_acc, out_acc;
  logic          issue, stream_done, final_word;
  logic [IW-1:0] rd_addr;
  logic          a_we, b_we;
  logic [IW-1:0] a_wa, b_wa;
  logic [EW-1:0] a_wd, b_wd;
  logic [EW-1:0] rd_word;
  logic [SW-1:0] quot, ten_quot;
  logic [3:0]    digit, cs_idx;
  logic [CW-1:0] cs_rd;
  logic          stream_st;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign stream_st   = (st_q == ST_COUNT) || (st_q == ST_SCATTER);
  assign issue       = stream_st && (idx_q != cnt_q);
  assign stream_done = (idx_q == cnt_q) && !s1_v_q && !s2_v_q;
  assign final_word  = (idx_q == cnt_q - CW'(1));

  // shared divide-by-ten unit, second half: quotient and remainder digit
  assign rd_word  = src_q ? b_rd_q : a_rd_q;
  assign quot     = SW'(prod_q >> RecipShift);
  assign ten_quot = (quot << 3) + (quot << 1);
  assign digit    = 4'(q_s2_q - ten_quot);
  assign cs_idx   = (st_q == ST_PREFIX) ? pidx_q : digit;
  assign cs_rd    = cs_q[cs_idx];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_LOAD:     if (in_acc && last_item_i) st_d = ST_CLEAR;
      ST_CLEAR:    st_d = ST_COUNT;
      ST_COUNT:    if (stream_done) st_d = ST_PREFIX;
      ST_PREFIX:   if (pidx_q == DigitLast) st_d = ST_SCATTER;
      ST_SCATTER:  if (stream_done) st_d = more_q ? ST_CLEAR : ST_OUT_RD;
      ST_OUT_RD:   st_d = ST_OUT_LD;
      ST_OUT_LD:   st_d = ST_OUT_WAIT;
      ST_OUT_WAIT: if (out_acc) st_d = final_word ? ST_LOAD : ST_OUT_LD;
      default:     st_d = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall_o  = (st_q != ST_LOAD);
    out_valid_o = (st_q == ST_OUT_WAIT);
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    src_d       = src_q;
    more_d      = more_q;
    pidx_d      = pidx_q;
    acc_d       = acc_q;
    rd_addr     = idx_q[IW-1:0];
    a_we        = 1'b0;
    b_we        = 1'b0;
    a_wa        = cnt_q[IW-1:0];
    b_wa        = cnt_q[IW-1:0];
    a_wd        = {value_i[SW-1:0], value_i[SW-1:0]};
    b_wd        = {val_s2_q, quot};
    case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q != MaxCount) begin
            a_we  = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        idx_d  = '0;
        more_d = 1'b0;
      end
      ST_COUNT: begin
        if (issue) idx_d = idx_q + CW'(1);
        if (stream_done) begin
          pidx_d = '0;
          acc_d  = '0;
        end
      end
      ST_PREFIX: begin
        acc_d  = acc_q + cs_rd;
        pidx_d = pidx_q + 4'd1;
        idx_d  = '0;
      end
      ST_SCATTER: begin
        if (issue) idx_d = idx_q + CW'(1);
        if (s2_v_q) begin
          a_wa = cs_rd[IW-1:0];
          b_wa = cs_rd[IW-1:0];
          a_wd = {val_s2_q, quot};
          a_we = src_q;
          b_we = !src_q;
          if (quot != '0) more_d = 1'b1;
        end
        if (stream_done) begin
          src_d = !src_q;
          idx_d = '0;
        end
      end
      ST_OUT_WAIT: begin
        if (out_acc) begin
          if (final_word) begin
            cnt_d     = '0;
            dropped_d = 1'b0;
            src_d     = 1'b0;
          end else begin
            idx_d   = idx_q + CW'(1);
            rd_addr = IW'(idx_q + CW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_LOAD;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      idx_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      src_q     <= 1'b0;
      more_q    <= 1'b0;
      pidx_q    <= '0;
      acc_q     <= '0;
      for (int i = 0; i < DigitBase; i++) cs_q[i] <= '0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      s1_v_q    <= issue;
      s2_v_q    <= s1_v_q;
      src_q     <= src_d;
      more_q    <= more_d;
      pidx_q    <= pidx_d;
      acc_q     <= acc_d;
      if (st_q == ST_CLEAR) begin
        for (int i = 0; i < DigitBase; i++) cs_q[i] <= '0;
      end else if (st_q == ST_PREFIX) begin
        // turn counts into bucket start offsets
        cs_q[cs_idx] <= acc_q;
      end else if (stream_st && s2_v_q) begin
        cs_q[cs_idx] <= cs_rd + CW'(1);
      end
    end
  end

  // shared divide-by-ten unit, first half: reciprocal multiply
  always_ff @(posedge clk_i) begin
    prod_q   <= PW'(rd_word[SW-1:0]) * PW'(RecipTen);
    val_s2_q <= rd_word[EW-1:SW];
    q_s2_q   <= rd_word[SW-1:0];
    if (st_q == ST_OUT_LD) begin
      sorted_q <= FieldBits'(rd_word[EW-1:SW]);
      last_q   <= final_word;
      ovf_q    <= dropped_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    a_rd_q <= mem_a[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) mem_b[b_wa] <= b_wd;
    b_rd_q <= mem_b[rd_addr];
  end

  assign sorted_value_o = sorted_q;
  assign last_out_o     = last_q;
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

/* test/tb_lsd_decimal_radix_sort.sv */
// Testbench for lsd_decimal_radix_sort: feeds sets of words and checks each
// sorted word, its last mark and its overflow flag against a local sorter.
// Depends on ldrs_pkg and the lsd_decimal_radix_sort RTL.
`default_nettype none

module tb_lsd_decimal_radix_sort;
  import ldrs_pkg::*;

  localparam int SetCap      = 64;
  localparam int ValueBits   = 31;
  localparam int RandomWords = 334;
  localparam int IdleLimit   = 20000;

  typedef logic [FieldBits-1:0] word_t;
  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_word_t;

  localparam word_t ValueMax = '1;

  class set_sort_board;
    word_t        held_words[$];
    bit           held_dropped;
    sorted_word_t expected_words[$];
    int           failures;
    int           sets_closed;
    int           dropped_sets;
    int           words_checked;

    function void note_word(word_t value, bit last);
      word_t kept;
      kept = value & word_t'((64'd1 << ValueBits) - 1);
      if (held_words.size() < SetCap) held_words.push_back(kept);
      else held_dropped = 1'b1;
      if (last) predict_sorted_set();
    endfunction

    // Stable ascending order of the held set, one expected word per entry.
    function void predict_sorted_set();
      word_t        order[$];
      word_t        w;
      int           j;
      sorted_word_t e;
      foreach (held_words[i]) begin
        w = held_words[i];
        j = order.size();
        while (j > 0 && order[j-1] > w) j--;
        order.insert(j, w);
      end
      foreach (order[k]) begin
        e.value = order[k];
        e.last  = (k == order.size() - 1);
        e.ovf   = held_dropped;
        expected_words.push_back(e);
      end
      if (held_dropped) dropped_sets++;
      sets_closed++;
      held_words.delete();
      held_dropped = 1'b0;
    endfunction

    function void check_word(word_t value, bit last, bit ovf);
      sorted_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: value %0d last %0b overflow %0b",
                 $time, value, last, ovf);
        failures++;
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (value !== e.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, e.value, value);
        failures++;
      end
      if (last !== e.last) begin
        $display("%0t: last_out expected %0b actual %0b (value %0d)",
                 $time, e.last, last, e.value);
        failures++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %0b actual %0b (value %0d)",
                 $time, e.ovf, ovf, e.value);
        failures++;
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  word_t value_i;
  logic  last_item_i;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t sorted_value_o;
  logic  last_out_o;
  logic  overflow_o;

  set_sort_board board = new();
  word_t         set_words[$];
  int            words_sent;
  int            idle_cycles = 0;
  int            stall_hold = 0;

  lsd_decimal_radix_sort u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Output stall: runs of no stall, short stalls and a few long ones.
  always @(posedge clk_i) begin
    int r;
    if (stall_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(1, 20);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(10, 40);
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
      board.check_word(sorted_value_o, last_out_o, overflow_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of repeats, full-width noise, extremes and values of a chosen digit count.
  function automatic word_t rand_value(word_t prev);
    int     r;
    int     digits;
    longint scale;
    longint lo;
    longint hi;
    r = $urandom_range(0, 99);
    if (r < 10) return prev;
    if (r < 22) return word_t'($urandom);
    if (r < 24) return '0;
    if (r < 26) return ValueMax;
    digits = $urandom_range(1, 10);
    scale  = 1;
    repeat (digits - 1) scale = scale * 10;
    lo = (digits == 1) ? 0 : scale;
    hi = scale * 10 - 1;
    if (hi > longint'(ValueMax)) hi = longint'(ValueMax);
    return word_t'(lo + longint'($urandom % (hi - lo + 1)));
  endfunction

  task automatic send_word(input word_t value, input bit last, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= value;
    last_item_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_word(value, last);
    words_sent++;
  endtask

  task automatic send_set(input bit steady);
    foreach (set_words[i])
      send_word(set_words[i], i == set_words.size() - 1, steady ? 0 : pick_gap());
  endtask

  // Hold the input until every expected word has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_words.size() != 0);
  endtask

  initial begin
    int    set_idx;
    int    set_size;
    int    r;
    word_t prev;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    last_item_i = 1'b0;
    words_sent  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single zero (one pass), single largest value, digit boundaries, repeats.
    set_words = '{word_t'(0)};
    send_set(1'b1);
    set_words = '{ValueMax};
    send_set(1'b0);
    set_words = '{word_t'(9), word_t'(10), word_t'(0), word_t'(99), word_t'(100),
                  ValueMax, word_t'(1), word_t'(10), word_t'(9),
                  word_t'(1000000000), word_t'(999999999)};
    send_set(1'b1);
    set_words = '{word_t'(5), word_t'(5), word_t'(5)};
    send_set(1'b0);

    // Random sets: the first ones overflow or fill the store exactly.
    set_idx = 0;
    prev    = '0;
    while (words_sent < RandomWords + 16) begin
      r = $urandom_range(0, 99);
      case (set_idx)
        0: set_size = 66;
        1: set_size = 64;
        2: set_size = 65;
        default: begin
          set_size = (r < 8) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        end
      endcase
      if (set_idx == 3 || $urandom_range(0, 4) == 0) drain_results();
      set_words.delete();
      repeat (set_size) begin
        prev = rand_value(prev);
        set_words.push_back(prev);
      end
      send_set($urandom_range(0, 3) == 0);
      set_idx++;
    end

    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d words in %0d sets (%0d sets overflowed the store).",
             words_sent, board.sets_closed, board.dropped_sets);
    $display("Checked %0d sorted words, %0d mismatches.",
             board.words_checked, board.failures);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
